@@ src/calt_pkg.sv @@
package calt_pkg;

    // Table geometry and result limits
    localparam int SLOTS_DEF   = 16;
    localparam int MAX_REPORTS = 16;
    localparam int REP_W       = 5;
    localparam int SLOT_W      = 4;

    // Stream widths
    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 8;

    // Request types carried in s_tuser
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_ADD  = 1'b1;

    // Entry kinds
    localparam logic [1:0] KIND_REPEAT = 2'd0;
    localparam logic [1:0] KIND_COUNT  = 2'd1;
    localparam logic [1:0] KIND_ONCE   = 2'd2;

    // Add reply status
    localparam logic [1:0] ST_STORED   = 2'd0;
    localparam logic [1:0] ST_BAD_KIND = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    // Time limits
    localparam logic [6:0] MINUTE_MAX = 7'd59;
    localparam logic [6:0] MINUTES    = 7'd60;
    localparam logic [6:0] HOUR_MAX   = 7'd23;
    localparam logic [6:0] HOURS      = 7'd24;
    localparam logic [4:0] MONTHS     = 5'd12;
    localparam logic [7:0] DAY_SAT    = 8'd63;

    typedef struct packed {
        logic [3:0] month;
        logic [5:0] day;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [3:0] s_month;
        logic [4:0] s_day;
        logic [4:0] s_hour;
        logic [5:0] s_minute;
        logic [1:0] kind;
        logic [7:0] count;
        logic       removable;
        logic       done;
    } entry_t;

    // Controller to datapath
    typedef struct packed {
        logic tick_start;
        logic add_do;
        logic scan_step;
        logic flush_push;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic push_need;
        logic last_slot;
        logic pend_valid;
        logic out_free;
    } stat_t;

    function automatic entry_t advance_time(input entry_t e);
        entry_t     r;
        logic [6:0] m;
        logic [6:0] h;
        logic [7:0] d;
        logic [4:0] mo;
        r = e;
        m = {1'b0, e.minute} + {1'b0, e.s_minute};
        h = {2'b00, e.hour};
        d = {2'b00, e.day};
        if (m > MINUTE_MAX) begin
            m = m - MINUTES;
            h = h + 7'd1;
        end
        h = h + {2'b00, e.s_hour};
        if (h > HOUR_MAX) begin
            h = h - HOURS;
            d = d + 8'd1;
        end
        d = d + {3'b000, e.s_day};
        if (d > DAY_SAT) begin
            d = DAY_SAT;
        end
        mo = {1'b0, e.month} + {1'b0, e.s_month};
        if (mo > MONTHS) begin
            mo = mo - MONTHS;
        end
        r.minute = m[5:0];
        r.hour   = h[4:0];
        r.day    = d[5:0];
        r.month  = mo[3:0];
        return r;
    endfunction

endpackage

@@ src/calt_dp.sv @@
module calt_dp #(
    parameter int SLOTS = calt_pkg::SLOTS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  calt_pkg::cmd_t                   cmd,
    output calt_pkg::stat_t                  stat,
    input  logic [calt_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [calt_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                             m_tuser,
    output logic                             m_tlast
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    // Input fields
    logic [3:0] in_month;
    logic [4:0] in_day;
    logic [4:0] in_hour;
    logic [5:0] in_minute;
    logic [1:0] in_kind;
    calt_pkg::entry_t new_entry;

    assign in_month  = s_tdata[3:0];
    assign in_day    = s_tdata[8:4];
    assign in_hour   = s_tdata[13:9];
    assign in_minute = s_tdata[19:14];
    assign in_kind   = s_tdata[41:40];

    always_comb begin
        new_entry.month     = in_month;
        new_entry.day       = {1'b0, in_day};
        new_entry.hour      = in_hour;
        new_entry.minute    = in_minute;
        new_entry.s_month   = s_tdata[23:20];
        new_entry.s_day     = s_tdata[28:24];
        new_entry.s_hour    = s_tdata[33:29];
        new_entry.s_minute  = s_tdata[39:34];
        new_entry.kind      = in_kind;
        new_entry.count     = s_tdata[49:42];
        new_entry.removable = s_tdata[50];
        new_entry.done      = 1'b0;
    end

    // Entry memory and valid flags
    calt_pkg::entry_t mem [SLOTS];
    calt_pkg::entry_t rdata_reg;
    logic [SLOTS-1:0] valid_reg;
    logic [SLOTS-1:0] valid_next;

    // Scan state
    logic [IW-1:0]             idx_reg;
    logic [calt_pkg::REP_W-1:0] nrep_reg;
    logic [3:0]                t_month_reg;
    logic [4:0]                t_day_reg;
    logic [4:0]                t_hour_reg;
    logic [5:0]                t_minute_reg;

    // Pending report
    logic                       pend_valid_reg;
    logic                       pend_add_reg;
    logic [calt_pkg::SLOT_W-1:0] pend_slot_reg;
    logic [1:0]                 pend_status_reg;

    // Output register
    logic                       out_valid_reg;
    logic                       out_add_reg;
    logic [calt_pkg::SLOT_W-1:0] out_slot_reg;
    logic [1:0]                 out_status_reg;
    logic                       out_last_reg;

    logic                       last_slot;
    logic [IW-1:0]              rd_addr;
    logic                       hit;
    logic                       can_report;
    logic                       push_need;
    calt_pkg::entry_t           upd;
    calt_pkg::entry_t           cnt_tmp;
    logic                       free_found;
    logic [IW-1:0]              free_idx;
    logic                       add_ok;
    logic                       wr_en;
    logic [IW-1:0]              wr_addr;
    calt_pkg::entry_t           wr_data;
    logic                       load_out;

    assign last_slot  = (idx_reg == IW'(SLOTS - 1));
    assign can_report = (nrep_reg < calt_pkg::REP_W'(calt_pkg::MAX_REPORTS));

    assign hit = valid_reg[idx_reg]
        && (rdata_reg.month == t_month_reg)
        && (rdata_reg.day == {1'b0, t_day_reg})
        && (rdata_reg.hour == t_hour_reg)
        && (rdata_reg.minute == t_minute_reg);

    assign push_need = hit && pend_valid_reg && can_report;

    always_comb begin
        if (cmd.scan_step && !last_slot) begin
            rd_addr = idx_reg + IW'(1);
        end else if (cmd.tick_start) begin
            rd_addr = '0;
        end else begin
            rd_addr = idx_reg;
        end
    end

    // Lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!valid_reg[i]) begin
                free_found = 1'b1;
                free_idx   = IW'(i);
            end
        end
    end

    assign add_ok = (in_kind <= calt_pkg::KIND_ONCE) && free_found;

    // Next state of a firing entry that is not done
    always_comb begin
        cnt_tmp = rdata_reg;
        if (rdata_reg.count != 8'd0) begin
            cnt_tmp.count = rdata_reg.count - 8'd1;
            if (cnt_tmp.count == 8'd0) begin
                cnt_tmp.done = 1'b1;
            end
        end
        upd = rdata_reg;
        case (rdata_reg.kind)
            calt_pkg::KIND_REPEAT: upd = calt_pkg::advance_time(rdata_reg);
            calt_pkg::KIND_COUNT:  upd = calt_pkg::advance_time(cnt_tmp);
            default:               upd.done = 1'b1;
        endcase
    end

    // Single write port: add store or scan write-back
    always_comb begin
        wr_en      = 1'b0;
        wr_addr    = idx_reg;
        wr_data    = upd;
        valid_next = valid_reg;
        if (cmd.add_do && add_ok) begin
            wr_en               = 1'b1;
            wr_addr             = free_idx;
            wr_data             = new_entry;
            valid_next[free_idx] = 1'b1;
        end else if (cmd.scan_step && hit) begin
            if (rdata_reg.done) begin
                if (rdata_reg.removable) begin
                    valid_next[idx_reg] = 1'b0;
                end
            end else begin
                wr_en = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rdata_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Scan index, report count and tick time
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            nrep_reg <= '0;
        end else if (cmd.tick_start) begin
            idx_reg  <= '0;
            nrep_reg <= '0;
        end else if (cmd.scan_step) begin
            if (!last_slot) begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (hit && can_report) begin
                nrep_reg <= nrep_reg + calt_pkg::REP_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.tick_start) begin
            t_month_reg  <= in_month;
            t_day_reg    <= in_day;
            t_hour_reg   <= in_hour;
            t_minute_reg <= in_minute;
        end
    end

    // Pending report: held until the next report or the end of the scan proves it last
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
        end else if (cmd.add_do) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.scan_step && hit && can_report) begin
            pend_valid_reg <= 1'b1;
        end else if (cmd.flush_push) begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.add_do) begin
            pend_add_reg <= calt_pkg::REQ_ADD;
            if (in_kind > calt_pkg::KIND_ONCE) begin
                pend_status_reg <= calt_pkg::ST_BAD_KIND;
                pend_slot_reg   <= '0;
            end else if (!free_found) begin
                pend_status_reg <= calt_pkg::ST_FULL;
                pend_slot_reg   <= '0;
            end else begin
                pend_status_reg <= calt_pkg::ST_STORED;
                pend_slot_reg   <= calt_pkg::SLOT_W'(free_idx);
            end
        end else if (cmd.scan_step && hit && can_report) begin
            pend_add_reg    <= calt_pkg::REQ_TICK;
            pend_status_reg <= calt_pkg::ST_STORED;
            pend_slot_reg   <= calt_pkg::SLOT_W'(idx_reg);
        end
    end

    // Output register
    assign load_out = (cmd.scan_step && push_need) || cmd.flush_push;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_add_reg    <= pend_add_reg;
            out_slot_reg   <= pend_slot_reg;
            out_status_reg <= pend_status_reg;
            out_last_reg   <= cmd.flush_push;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00, out_status_reg, out_slot_reg};
    assign m_tuser  = out_add_reg;
    assign m_tlast  = out_last_reg;

    assign stat.push_need  = push_need;
    assign stat.last_slot  = last_slot;
    assign stat.pend_valid = pend_valid_reg;
    assign stat.out_free   = !out_valid_reg || m_tready;

endmodule

@@ src/calt_ctrl.sv @@
module calt_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic            s_tuser,
    input  calt_pkg::stat_t stat,
    output calt_pkg::cmd_t  cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_FLUSH = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == calt_pkg::REQ_ADD) begin
                        cmd.add_do = 1'b1;
                        state_next = S_FLUSH;
                    end else begin
                        cmd.tick_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                // hold the slot while a report must leave and the output is full
                if (!(stat.push_need && !stat.out_free)) begin
                    cmd.scan_step = 1'b1;
                    if (stat.last_slot) begin
                        state_next = S_FLUSH;
                    end
                end
            end
            S_FLUSH: begin
                if (!stat.pend_valid) begin
                    state_next = S_IDLE;
                end else if (stat.out_free) begin
                    cmd.flush_push = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    a_cmd_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0({cmd.tick_start, cmd.add_do, cmd.scan_step, cmd.flush_push}))
        else $error("more than one datapath command at once");

    a_idle_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> !stat.pend_valid)
        else $error("pending report left behind at idle");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.scan_step && stat.push_need) || cmd.flush_push |-> stat.out_free)
        else $error("report pushed into a full output register");

endmodule

@@ src/calendar_alarm_table_top.sv @@
// Alarm table: SLOTS entries of month/day/hour/minute plus step, kind, count
// and removable flag.
// Input channel (s_): s_tuser is the request type (0 tick, 1 add); s_tdata
// carries the time and entry fields. An add stores into the lowest free slot
// and returns one reply beat (status stored, bad kind or table full). A tick
// walks every slot and returns one beat per matching entry in slot order,
// at most 16; a tick with no match returns nothing.
// Output channel (m_): m_tuser flags an add reply, m_tdata carries slot and
// status, m_tlast marks the last beat of the request.
// Flow: an add's reply goes through the pending register, then the output
// register; a tick is a scan that reads one entry per cycle, unless stalled
// by a full output register, from the entry memory (one read port and a
// single write port) and writes back the updated entry behind it. One
// request is handled at a time; s_tready is high only while idle.
// A report waits in a pending register until the next match or the end of
// the scan proves it last, then moves to the output register. Stall the scan
// or the final push while the output register holds a beat not yet taken.
// Reset clears the valid flags, the controller and the output register;
// the entry memory is not cleared and needs no clearing pass.
module calendar_alarm_table_top #(
    parameter int SLOTS = calt_pkg::SLOTS_DEF
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // month[3:0] day[8:4] hour[13:9] minute[19:14] step_month[23:20]
    // step_day[28:24] step_hour[33:29] step_minute[39:34] kind[41:40]
    // repeat_count[49:42] removable[50], zero above
    input  logic [calt_pkg::S_TDATA_W-1:0] s_tdata,
    // req_type
    input  logic                           s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // fired_slot[3:0] add_status[5:4], zero above
    output logic [calt_pkg::M_TDATA_W-1:0] m_tdata,
    // is_add_reply
    output logic                           m_tuser,
    output logic                           m_tlast
);

    calt_pkg::cmd_t  cmd;
    calt_pkg::stat_t stat;

    // Sequence adds, the slot scan and the final report
    calt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Hold the entries, evaluate matches and drive the output beat
    calt_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

localparam logic [1:0] KIND_BAD = 2'd3;  // refused by the block

typedef struct {
    logic       req_type;
    logic [3:0] month;
    logic [4:0] day;
    logic [4:0] hour;
    logic [5:0] minute;
    logic [3:0] step_month;
    logic [4:0] step_day;
    logic [4:0] step_hour;
    logic [5:0] step_minute;
    logic [1:0] kind;
    logic [7:0] repeat_count;
    logic       removable;
} alarm_req_t;

typedef struct {
    logic       is_add_reply;
    logic [3:0] slot;
    logic [1:0] status;
    logic       last;
} alarm_report_t;

// Predicts the alarm table and checks each result beat against it.
class alarm_checker;
    calt_pkg::entry_t alarms[calt_pkg::SLOTS_DEF];
    bit               alarm_live[calt_pkg::SLOTS_DEF];
    alarm_report_t    pending_reports[$];
    int               errors;

    // Step an entry's time: minutes carry into hours, hours into days,
    // the day saturates and the month wraps once.
    function calt_pkg::entry_t stepped_time(calt_pkg::entry_t e);
        int mins;
        int hrs;
        int days;
        int mons;
        mins = e.minute + e.s_minute;
        hrs  = e.hour;
        days = e.day;
        if (mins > calt_pkg::MINUTE_MAX) begin
            mins = mins - calt_pkg::MINUTES;
            hrs  = hrs + 1;
        end
        hrs = hrs + e.s_hour;
        if (hrs > calt_pkg::HOUR_MAX) begin
            hrs  = hrs - calt_pkg::HOURS;
            days = days + 1;
        end
        days = days + e.s_day;
        if (days > calt_pkg::DAY_SAT) begin
            days = calt_pkg::DAY_SAT;
        end
        mons = e.month + e.s_month;
        if (mons > calt_pkg::MONTHS) begin
            mons = mons - calt_pkg::MONTHS;
        end
        e.minute = mins[5:0];
        e.hour   = hrs[4:0];
        e.day    = days[5:0];
        e.month  = mons[3:0];
        return e;
    endfunction

    function void push_report(logic is_add, logic [3:0] slot, logic [1:0] status);
        alarm_report_t rep;
        rep.is_add_reply = is_add;
        rep.slot         = slot;
        rep.status       = status;
        rep.last         = 1'b0;
        pending_reports = {pending_reports, rep};
    endfunction

    function void predict_add(alarm_req_t r);
        int free_slot;
        free_slot = -1;
        if (r.kind == KIND_BAD) begin
            push_report(1'b1, 4'd0, calt_pkg::ST_BAD_KIND);
        end else begin
            for (int i = 0; i < calt_pkg::SLOTS_DEF; i++) begin
                if (!alarm_live[i] && free_slot < 0) begin
                    free_slot = i;
                end
            end
            if (free_slot < 0) begin
                push_report(1'b1, 4'd0, calt_pkg::ST_FULL);
            end else begin
                alarms[free_slot].month     = r.month;
                alarms[free_slot].day       = {1'b0, r.day};
                alarms[free_slot].hour      = r.hour;
                alarms[free_slot].minute    = r.minute;
                alarms[free_slot].s_month   = r.step_month;
                alarms[free_slot].s_day     = r.step_day;
                alarms[free_slot].s_hour    = r.step_hour;
                alarms[free_slot].s_minute  = r.step_minute;
                alarms[free_slot].kind      = r.kind;
                alarms[free_slot].count     = r.repeat_count;
                alarms[free_slot].removable = r.removable;
                alarms[free_slot].done      = 1'b0;
                alarm_live[free_slot]       = 1'b1;
                push_report(1'b1, free_slot[3:0], calt_pkg::ST_STORED);
            end
        end
        pending_reports[pending_reports.size() - 1].last = 1'b1;
    endfunction

    function void predict_tick(alarm_req_t r);
        int fired;
        fired = 0;
        for (int i = 0; i < calt_pkg::SLOTS_DEF; i++) begin
            if (alarm_live[i] && alarms[i].month == r.month && alarms[i].day == {1'b0, r.day}
                    && alarms[i].hour == r.hour && alarms[i].minute == r.minute) begin
                if (fired < calt_pkg::MAX_REPORTS) begin
                    push_report(1'b0, i[3:0], calt_pkg::ST_STORED);
                    fired++;
                end
                if (alarms[i].done) begin
                    // done: free it if removable, else leave it alone
                    if (alarms[i].removable) begin
                        alarm_live[i] = 1'b0;
                    end
                end else if (alarms[i].kind == calt_pkg::KIND_REPEAT) begin
                    alarms[i] = stepped_time(alarms[i]);
                end else if (alarms[i].kind == calt_pkg::KIND_COUNT) begin
                    // a zero count means unlimited
                    if (alarms[i].count != 8'd0) begin
                        alarms[i].count = alarms[i].count - 8'd1;
                        if (alarms[i].count == 8'd0) begin
                            alarms[i].done = 1'b1;
                        end
                    end
                    alarms[i] = stepped_time(alarms[i]);
                end else begin
                    alarms[i].done = 1'b1;
                end
            end
        end
        if (fired > 0) begin
            pending_reports[pending_reports.size() - 1].last = 1'b1;
        end
    endfunction

    function void record_request(alarm_req_t r);
        if (r.req_type == calt_pkg::REQ_ADD) begin
            predict_add(r);
        end else begin
            predict_tick(r);
        end
    endfunction

    function void check_report(logic user, logic [calt_pkg::M_TDATA_W-1:0] data, logic last);
        alarm_report_t exp_rep;
        if (pending_reports.size() == 0) begin
            $display("%0t: unexpected beat: user=%b data=%h last=%b", $time, user, data, last);
            errors++;
        end else begin
            exp_rep = pending_reports.pop_front();
            if (user !== exp_rep.is_add_reply || data[3:0] !== exp_rep.slot
                    || data[5:4] !== exp_rep.status || data[7:6] !== 2'b00
                    || last !== exp_rep.last) begin
                $display({"%0t: mismatch: expected add=%b slot=%0d status=%0d last=%b, ",
                          "actual add=%b slot=%0d status=%0d pad=%b last=%b"},
                         $time, exp_rep.is_add_reply, exp_rep.slot, exp_rep.status,
                         exp_rep.last, user, data[3:0], data[5:4], data[7:6], last);
                errors++;
            end
        end
    endfunction

    // Pick the current time of a live entry that a tick can still hit.
    function bit pick_alarm_time(output logic [3:0] mo, output logic [4:0] dy,
                                 output logic [4:0] hr, output logic [5:0] mi);
        int hits[$];
        int k;
        mo = 4'd0;
        dy = 5'd0;
        hr = 5'd0;
        mi = 6'd0;
        for (int i = 0; i < calt_pkg::SLOTS_DEF; i++) begin
            if (alarm_live[i] && alarms[i].day < 6'd32) begin
                hits = {hits, i};
            end
        end
        if (hits.size() == 0) begin
            return 1'b0;
        end
        k  = hits[$urandom_range(hits.size() - 1)];
        mo = alarms[k].month;
        dy = alarms[k].day[4:0];
        hr = alarms[k].hour;
        mi = alarms[k].minute;
        return 1'b1;
    endfunction

    function void report_leftovers();
        foreach (pending_reports[i]) begin
            $display("%0t: missing beat: expected add=%b slot=%0d status=%0d last=%b, actual none",
                     $time, pending_reports[i].is_add_reply, pending_reports[i].slot,
                     pending_reports[i].status, pending_reports[i].last);
            errors++;
        end
    endfunction
endclass

module tb_top;

    localparam int QUIET_LIMIT = 4000;
    localparam int RANDOM_ITEMS = 75;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [calt_pkg::S_TDATA_W-1:0] s_tdata = '0;
    logic                           s_tuser = 1'b0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [calt_pkg::M_TDATA_W-1:0] m_tdata;
    logic                           m_tuser;
    logic                           m_tlast;

    int sender_idle_pct = 16;
    int receiver_idle_pct = 86;
    int quiet_cycles = 0;

    alarm_checker scb;

    calendar_alarm_table_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Receiver: stall at random at the current idle rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            scb.check_report(m_tuser, m_tdata, m_tlast);
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("[calendar_alarm_table_top] ERROR");
        $finish;
    end

    function automatic logic [calt_pkg::S_TDATA_W-1:0] pack_request(alarm_req_t r);
        return {5'd0, r.removable, r.repeat_count, r.kind, r.step_minute, r.step_hour,
                r.step_day, r.step_month, r.minute, r.hour, r.day, r.month};
    endfunction

    // Hold valid across back-to-back beats; drop it only on an idle cycle.
    task automatic send_request(input alarm_req_t r);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= r.req_type;
        s_tdata  <= pack_request(r);
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        scb.record_request(r);
    endtask

    task automatic send_add(input logic [3:0] mo, input logic [4:0] dy, input logic [4:0] hr,
                            input logic [5:0] mi, input logic [3:0] smo, input logic [4:0] sdy,
                            input logic [4:0] shr, input logic [5:0] smi, input logic [1:0] kd,
                            input logic [7:0] cnt, input logic rem);
        alarm_req_t r;
        r.req_type     = calt_pkg::REQ_ADD;
        r.month        = mo;
        r.day          = dy;
        r.hour         = hr;
        r.minute       = mi;
        r.step_month   = smo;
        r.step_day     = sdy;
        r.step_hour    = shr;
        r.step_minute  = smi;
        r.kind         = kd;
        r.repeat_count = cnt;
        r.removable    = rem;
        send_request(r);
    endtask

    task automatic send_tick(input logic [3:0] mo, input logic [4:0] dy, input logic [4:0] hr,
                             input logic [5:0] mi);
        alarm_req_t r;
        r.req_type     = calt_pkg::REQ_TICK;
        r.month        = mo;
        r.day          = dy;
        r.hour         = hr;
        r.minute       = mi;
        // entry fields are ignored on a tick; fill them with noise
        r.step_month   = 4'($urandom);
        r.step_day     = 5'($urandom);
        r.step_hour    = 5'($urandom);
        r.step_minute  = 6'($urandom);
        r.kind         = 2'($urandom);
        r.repeat_count = 8'($urandom);
        r.removable    = 1'($urandom);
        send_request(r);
    endtask

    function automatic alarm_req_t random_add();
        alarm_req_t r;
        int sel;
        r.req_type = calt_pkg::REQ_ADD;
        sel = $urandom_range(99);
        if (sel < 10) begin
            r.kind = KIND_BAD;
        end else if (sel < 22) begin
            r.kind = calt_pkg::KIND_REPEAT;
        end else if (sel < 60) begin
            r.kind = calt_pkg::KIND_COUNT;
        end else begin
            r.kind = calt_pkg::KIND_ONCE;
        end
        if ($urandom_range(7) == 0) begin
            r.month  = 4'($urandom);
            r.day    = 5'($urandom);
            r.hour   = 5'($urandom);
            r.minute = 6'($urandom);
        end else begin
            r.month  = 4'($urandom_range(12, 1));
            r.day    = 5'($urandom_range(31, 1));
            r.hour   = 5'($urandom_range(23));
            r.minute = 6'($urandom_range(59));
        end
        // keep steps small mostly so days stay reachable by a tick
        if ($urandom_range(5) == 0) begin
            r.step_month  = 4'($urandom);
            r.step_day    = 5'($urandom);
            r.step_hour   = 5'($urandom);
            r.step_minute = 6'($urandom);
        end else begin
            r.step_month  = 4'($urandom_range(2));
            r.step_day    = 5'($urandom_range(1));
            r.step_hour   = 5'($urandom_range(3));
            r.step_minute = 6'($urandom_range(59));
        end
        if ($urandom_range(11) == 0) begin
            r.repeat_count = 8'd0;
        end else if ($urandom_range(9) == 0) begin
            r.repeat_count = 8'($urandom);
        end else begin
            r.repeat_count = 8'($urandom_range(3, 1));
        end
        r.removable = ($urandom_range(9) != 0);
        return r;
    endfunction

    task automatic send_random_item();
        logic [3:0] mo;
        logic [4:0] dy;
        logic [4:0] hr;
        logic [5:0] mi;
        int         sel;
        sel = $urandom_range(99);
        if (sel < 45) begin
            send_request(random_add());
        end else if (sel < 90 && scb.pick_alarm_time(mo, dy, hr, mi)) begin
            send_tick(mo, dy, hr, mi);
        end else begin
            send_tick(4'($urandom), 5'($urandom), 5'($urandom), 6'($urandom));
        end
    endtask

    initial begin : stimulus
        int per_phase;
        scb = new;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: empty-table tick, bad kind, fill the table at one time.
        send_tick(4'd1, 5'd1, 5'd0, 6'd0);
        send_add(4'd1, 5'd1, 5'd0, 6'd0, 4'd0, 5'd0, 5'd0, 6'd0, KIND_BAD, 8'd0, 1'b0);
        for (int i = 0; i < calt_pkg::SLOTS_DEF; i++) begin
            send_add(4'd1, 5'd1, 5'd0, 6'd0, 4'(i % 13), 5'(i * 2), 5'(i + 8),
                     6'(59 - i * 3),
                     (i % 3 == 0) ? calt_pkg::KIND_REPEAT :
                     (i % 3 == 1) ? calt_pkg::KIND_COUNT : calt_pkg::KIND_ONCE,
                     (i == 1) ? 8'd0 : (i == 4) ? 8'd1 : 8'd2, (i % 4 != 3));
        end
        // full table, then bad kind on a full table (bad kind wins)
        send_add(4'd3, 5'd3, 5'd3, 6'd3, 4'd0, 5'd0, 5'd0, 6'd1, calt_pkg::KIND_ONCE,
                 8'd0, 1'b1);
        send_add(4'd3, 5'd3, 5'd3, 6'd3, 4'd0, 5'd0, 5'd0, 6'd1, KIND_BAD, 8'd0, 1'b1);
        // every slot fires at once, then the done once-entries fire again and the removable ones free
        send_tick(4'd1, 5'd1, 5'd0, 6'd0);
        send_tick(4'd1, 5'd1, 5'd0, 6'd0);
        // extreme fields: all carries and wraps on one advance
        send_add(4'd15, 5'd31, 5'd31, 6'd63, 4'd15, 5'd31, 5'd31, 6'd63, calt_pkg::KIND_COUNT,
                 8'd255, 1'b1);
        send_tick(4'd15, 5'd31, 5'd31, 6'd63);
        send_tick(4'd12, 5'd31, 5'd23, 6'd59);

        // Random: three idle profiles in turn.
        per_phase = RANDOM_ITEMS / 3;
        for (int phase = 0; phase < 3; phase++) begin
            sender_idle_pct   = (phase == 0) ? 16 : (phase == 1) ? 86 : 0;
            receiver_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 16 : 0;
            repeat (per_phase + ((phase == 2) ? RANDOM_ITEMS % 3 : 0)) begin
                send_random_item();
            end
        end
        s_tvalid <= 1'b0;

        // Drain, then allow one more scan for stray beats.
        while (scb.pending_reports.size() != 0) begin
            @(posedge aclk);
        end
        repeat (2 * calt_pkg::SLOTS_DEF + 8) @(posedge aclk);
        scb.report_leftovers();
        if (scb.errors == 0) begin
            $display("[calendar_alarm_table_top] OK");
        end else begin
            $display("[calendar_alarm_table_top] ERROR");
        end
        $finish;
    end

endmodule

@@ sim.f @@
src/calt_pkg.sv
src/calt_dp.sv
src/calt_ctrl.sv
src/calendar_alarm_table_top.sv
bench/tb_top.sv
